// ----- rtl/bba_pkg.sv -----
package bba_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 32;
    localparam int KIB_W    = 18;
    localparam int BYTES_W  = 28;
    localparam int BIT_W    = 5;   // bit position inside a map word
    localparam int ONES_W   = 6;   // 0..32 set bits in a map word

    localparam logic [KIB_W-1:0] KIB_RESET = 18'd131072;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC_FIRST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC_AT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FREE        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATS       = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNALIGNED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE       = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 3'd4;

    // per-word scan result
    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  first;
        logic [ONES_W-1:0] ones;
    } scan_t;

endpackage

// ----- rtl/bitmap_block_allocator.sv -----
// Bitmap block allocator: one used bit per BLOCK_BYTES block, up to MAX_BLOCKS
// blocks, held in an on-chip map of MAX_BLOCKS/32 words of 32 bits (one read
// and one write port). Requests come on the req channel, one result per
// request leaves on the rsp channel. Claim, free and query read one map word
// and go through ST_OP and ST_DONE to the result. First-free allocation and
// stats walk the map one word per cycle through a shared word scan unit;
// allocation stops at the first word with a free block. The request side
// stalls while a request is at work and takes the next one the cycle after a
// result is loaded; a finished result waits in the output register without
// holding up the next request. After reset a clearing pass writes every map
// word (block 0 used) before the first request is taken; config writes are
// taken at any time but must only be issued while the block is idle.
// total_kib sets installed memory; blocks at or above the limit it gives
// read as used to queries, cannot be claimed and are left out of stats.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS  = 32768,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // config write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::KIB_W-1:0]     total_kib,

    // request
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [bba_pkg::KIND_W-1:0]    kind,
    input  logic [bba_pkg::ADDR_W-1:0]    block_addr,

    // response
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [bba_pkg::ADDR_W-1:0]    result_addr,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    output logic                          is_used,
    output logic [bba_pkg::BYTES_W-1:0]   used_bytes,
    output logic [bba_pkg::BYTES_W-1:0]   mem_size_bytes
);

    localparam int WORDS  = (MAX_BLOCKS + 31) / 32;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WC_W   = $clog2(WORDS + 1);
    localparam int LIM_W  = $clog2(MAX_BLOCKS + 1);
    localparam int BB_LOG = $clog2(BLOCK_BYTES);
    localparam int BA_W   = WA_W + bba_pkg::BIT_W + BB_LOG;
    localparam int UB_W   = LIM_W + BB_LOG;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_OP   = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // control
    logic [2:0]                    state_reg, state_next;
    logic [WC_W-1:0]               ptr_reg, ptr_next;
    logic                          pend_reg, pend_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [bba_pkg::KIB_W-1:0]     total_kib_reg, total_kib_next;

    // working payload
    logic [WA_W-1:0]               pend_w_reg, pend_w_next;
    logic [bba_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [bba_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [bba_pkg::ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [bba_pkg::STATUS_W-1:0]  stat_reg, stat_next;
    logic                          used_reg, used_next;
    logic [LIM_W-1:0]              cnt_reg, cnt_next;

    // output register
    logic [bba_pkg::ADDR_W-1:0]    result_addr_reg, result_addr_next;
    logic [bba_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          is_used_reg, is_used_next;
    logic [bba_pkg::BYTES_W-1:0]   used_bytes_reg, used_bytes_next;
    logic [bba_pkg::BYTES_W-1:0]   mem_size_bytes_reg, mem_size_bytes_next;

    // map memory
    logic [bba_pkg::WORD_W-1:0]    map_mem [WORDS];
    logic [bba_pkg::WORD_W-1:0]    rd_data_reg;
    logic                          rd_en, wr_en;
    logic [WA_W-1:0]               rd_addr, wr_addr;
    logic [bba_pkg::WORD_W-1:0]    wr_data;

    // derived values
    logic [bba_pkg::BYTES_W-1:0]   mem_bytes;
    logic [bba_pkg::BYTES_W-1:0]   blocks_raw;
    logic [LIM_W-1:0]              limit;
    logic [LIM_W:0]                limit_up;
    logic [WC_W-1:0]               nwords;
    logic [LIM_W:0]                rem_bits;
    logic [bba_pkg::ONES_W-1:0]    nvalid;
    bba_pkg::scan_t                scan;

    logic [bba_pkg::ADDR_W-1:0]    idx;
    logic                          aligned, beyond_max, beyond_lim, cur_bit;
    logic [bba_pkg::WORD_W-1:0]    bit_mask;
    logic [BA_W-1:0]               blk_byte;
    logic [UB_W-1:0]               ub_wide;

    assign cfg_ready      = 1'b1;
    assign req_stall      = (state_reg != ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign result_addr    = result_addr_reg;
    assign status         = status_reg;
    assign is_used        = is_used_reg;
    assign used_bytes     = used_bytes_reg;
    assign mem_size_bytes = mem_size_bytes_reg;

    // blocks in memory = min(total_kib*1024 / BLOCK_BYTES, MAX_BLOCKS)
    assign mem_bytes  = {total_kib_reg, 10'b0};
    assign blocks_raw = mem_bytes >> BB_LOG;
    assign limit      = (blocks_raw >= bba_pkg::BYTES_W'(MAX_BLOCKS))
                      ? LIM_W'(MAX_BLOCKS) : LIM_W'(blocks_raw);
    assign limit_up   = {1'b0, limit} + (LIM_W+1)'(31);
    assign nwords     = WC_W'(limit_up >> 5);

    // bits of the word under scan that are inside memory
    assign rem_bits = (LIM_W+1)'(limit) - (LIM_W+1)'({pend_w_reg, 5'b0});
    assign nvalid   = (rem_bits >= (LIM_W+1)'(32)) ? bba_pkg::ONES_W'(32)
                    : bba_pkg::ONES_W'(rem_bits);

    bba_word_scan u_scan (
        .word   (rd_data_reg),
        .nvalid (nvalid),
        .scan   (scan)
    );

    // single-block request decode
    assign idx        = addr_reg >> BB_LOG;
    assign aligned    = (addr_reg[BB_LOG-1:0] == '0);
    assign beyond_max = (idx >= bba_pkg::ADDR_W'(MAX_BLOCKS));
    assign beyond_lim = (idx >= bba_pkg::ADDR_W'(limit));
    assign cur_bit    = rd_data_reg[idx[bba_pkg::BIT_W-1:0]];
    assign bit_mask   = bba_pkg::WORD_W'(1) << idx[bba_pkg::BIT_W-1:0];

    assign blk_byte = {pend_w_reg, scan.first, {BB_LOG{1'b0}}};
    assign ub_wide  = {cnt_reg, {BB_LOG{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        ptr_next            = ptr_reg;
        pend_next           = pend_reg;
        rsp_valid_next      = rsp_valid_reg;
        total_kib_next      = total_kib_reg;
        pend_w_next         = pend_w_reg;
        kind_next           = kind_reg;
        addr_next           = addr_reg;
        res_addr_next       = res_addr_reg;
        stat_next           = stat_reg;
        used_next           = used_reg;
        cnt_next            = cnt_reg;
        result_addr_next    = result_addr_reg;
        status_next         = status_reg;
        is_used_next        = is_used_reg;
        used_bytes_next     = used_bytes_reg;
        mem_size_bytes_next = mem_size_bytes_reg;
        rd_en               = 1'b0;
        rd_addr             = ptr_reg[WA_W-1:0];
        wr_en               = 1'b0;
        wr_addr             = ptr_reg[WA_W-1:0];
        wr_data             = '0;

        if (cfg_valid)
        begin
            total_kib_next = total_kib;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                // reset sweep: block 0 reserved, everything else free
                wr_en   = 1'b1;
                wr_data = (ptr_reg == '0) ? bba_pkg::WORD_W'(1) : '0;
                if (ptr_reg == WC_W'(WORDS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + WC_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next     = kind;
                    addr_next     = block_addr;
                    res_addr_next = '0;
                    stat_next     = bba_pkg::STATUS_OK;
                    used_next     = 1'b0;
                    cnt_next      = '0;
                    ptr_next      = '0;
                    pend_next     = 1'b0;
                    // fetch the word of the addressed block right away
                    rd_en         = 1'b1;
                    rd_addr       = block_addr[BB_LOG + bba_pkg::BIT_W +: WA_W];
                    unique case (kind) inside
                        bba_pkg::KIND_ALLOC_FIRST, bba_pkg::KIND_STATS:
                            state_next = ST_SCAN;
                        bba_pkg::KIND_ALLOC_AT, bba_pkg::KIND_FREE, bba_pkg::KIND_QUERY:
                            state_next = ST_OP;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end

            ST_OP:
            begin
                wr_addr    = addr_reg[BB_LOG + bba_pkg::BIT_W +: WA_W];
                state_next = ST_DONE;
                if (!aligned)
                begin
                    stat_next = bba_pkg::STATUS_UNALIGNED;
                end
                else
                begin
                    case (kind_reg)
                        bba_pkg::KIND_ALLOC_AT:
                        begin
                            if (beyond_max)
                            begin
                                stat_next = bba_pkg::STATUS_RANGE;
                            end
                            else if (beyond_lim || cur_bit)
                            begin
                                stat_next = bba_pkg::STATUS_NONE;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_data       = rd_data_reg | bit_mask;
                                res_addr_next = addr_reg;
                            end
                        end
                        bba_pkg::KIND_FREE:
                        begin
                            if (beyond_lim)
                            begin
                                stat_next = bba_pkg::STATUS_RANGE;
                            end
                            else if (!cur_bit)
                            begin
                                stat_next = bba_pkg::STATUS_DOUBLE_FREE;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = rd_data_reg & ~bit_mask;
                            end
                        end
                        default:
                        begin
                            // query
                            if (beyond_max)
                            begin
                                stat_next = bba_pkg::STATUS_RANGE;
                                used_next = 1'b1;
                            end
                            else
                            begin
                                used_next = beyond_lim || cur_bit;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one word read per cycle, evaluate the previous one
                if (ptr_reg < nwords)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[WA_W-1:0];
                    ptr_next    = ptr_reg + WC_W'(1);
                    pend_next   = 1'b1;
                    pend_w_next = ptr_reg[WA_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (kind_reg == bba_pkg::KIND_ALLOC_FIRST)
                    begin
                        if (scan.found)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = pend_w_reg;
                            wr_data       = rd_data_reg
                                          | (bba_pkg::WORD_W'(1) << scan.first);
                            res_addr_next = bba_pkg::ADDR_W'(blk_byte);
                            state_next    = ST_DONE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + LIM_W'(scan.ones);
                    end
                end
                else if (ptr_reg >= nwords)
                begin
                    state_next = ST_DONE;
                    if (kind_reg == bba_pkg::KIND_ALLOC_FIRST)
                    begin
                        stat_next = bba_pkg::STATUS_NONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    result_addr_next = res_addr_reg;
                    status_next      = stat_reg;
                    is_used_next     = used_reg;
                    if (kind_reg == bba_pkg::KIND_STATS)
                    begin
                        used_bytes_next     = bba_pkg::BYTES_W'(ub_wide);
                        mem_size_bytes_next = mem_bytes;
                    end
                    else
                    begin
                        used_bytes_next     = '0;
                        mem_size_bytes_next = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            total_kib_reg <= bba_pkg::KIB_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            total_kib_reg <= total_kib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_w_reg         <= pend_w_next;
        kind_reg           <= kind_next;
        addr_reg           <= addr_next;
        res_addr_reg       <= res_addr_next;
        stat_reg           <= stat_next;
        used_reg           <= used_next;
        cnt_reg            <= cnt_next;
        result_addr_reg    <= result_addr_next;
        status_reg         <= status_next;
        is_used_reg        <= is_used_next;
        used_bytes_reg     <= used_bytes_next;
        mem_size_bytes_reg <= mem_size_bytes_next;
    end

endmodule

// ----- rtl/bba_word_scan.sv -----
// One map word: lowest free bit and used-bit count, limited to the
// bits that lie inside installed memory.
module bba_word_scan (
    input  logic [bba_pkg::WORD_W-1:0] word,
    input  logic [bba_pkg::ONES_W-1:0] nvalid,
    output bba_pkg::scan_t             scan
);

    logic [bba_pkg::WORD_W-1:0] low_mask;
    logic [bba_pkg::WORD_W-1:0] free_bits;
    logic [bba_pkg::WORD_W-1:0] used_bits;

    always_comb
    begin
        for (int i = 0; i < bba_pkg::WORD_W; i++)
        begin
            low_mask[i] = (bba_pkg::ONES_W'(i) < nvalid);
        end
        free_bits = ~word & low_mask;
        used_bits = word & low_mask;
    end

    // priority encode, lowest bit wins
    always_comb
    begin
        scan.found = |free_bits;
        scan.first = '0;
        for (int i = bba_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                scan.first = bba_pkg::BIT_W'(i);
            end
        end
    end

    // popcount by nibbles
    always_comb
    begin
        logic [3:0] nib;
        scan.ones = '0;
        for (int n = 0; n < bba_pkg::WORD_W / 4; n++)
        begin
            nib = used_bits[4*n +: 4];
            scan.ones = scan.ones + bba_pkg::ONES_W'(nib[0]) + bba_pkg::ONES_W'(nib[1])
                      + bba_pkg::ONES_W'(nib[2]) + bba_pkg::ONES_W'(nib[3]);
        end
    end

endmodule
